// ===== hw/rtl/tfnl_pkg.sv =====
// ----------------------------------------------------------------------------
// tfnl_pkg
// Shared types and constants of the triangle face normal line pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tfnl_pkg;

    // Item kinds on the input tuser bit
    localparam logic OP_VERTEX = 1'b0;
    localparam logic OP_FACE   = 1'b1;

    // Reset value of the line length register, about 0.3 in Q16.16
    localparam logic [30:0] LINE_LENGTH_RESET = 31'd19661;

    // ceil(2^34 / 3): exact floor(x / 3) for x below 2^33 after a shift by 34
    localparam logic [32:0] RECIP3       = 33'd5726623062;
    localparam int          RECIP3_SHIFT = 34;

    // Normal components are brought below 2^RC_BITS before length and divide
    localparam int RC_BITS = 30;

    // Square root: 32 result bits, two per stage
    localparam int SQRT_STAGES = 16;
    // Divider: 32 quotient bits, two per stage
    localparam int DIV_STAGES  = 16;

    // Control and per-face values carried alongside the math
    typedef struct packed {
        logic             valid;
        logic             last;
        logic             degen;
        logic [2:0]       neg;
        logic [2:0][31:0] mid;
    } side_t;

    // One square root stage
    typedef struct packed {
        side_t            side;
        logic [2:0][60:0] num;
        logic [63:0]      rad;
        logic [33:0]      rem;
        logic [31:0]      root;
    } sqrt_t;

    // One divider stage, three lanes sharing a divisor
    typedef struct packed {
        side_t            side;
        logic [31:0]      len;
        logic [2:0][31:0] low;
        logic [2:0][32:0] rem;
        logic [2:0][31:0] quo;
    } qdiv_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tfnl_ram.sv =====
// ----------------------------------------------------------------------------
// tfnl_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfnl_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and read, read data held while rd_en is low
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_face_normal_line_top.sv =====
// ----------------------------------------------------------------------------
// triangle_face_normal_line_top
// Vertex store plus a face pipeline giving the centroid and the end point of
// a normal line of configurable length.
// ----------------------------------------------------------------------------
//  channel   | direction | beat
//  s_axis    | in        | vertex write (tuser 0) or face (tuser 1), tlast ends mesh
//  m_axis    | out       | centroid and line end, tuser degenerate flag
//  cfg       | in        | line length, Q16.16, 31 bits
//
//  One beat per cycle in, one face result per cycle out while the output is
//  not stalled; a vertex write yields no result. A face passes 43 register
//  stages, most of them in the square root and divider pipelines (two bits
//  per stage each). A vertex written in one cycle is seen by a face in the
//  next. Reset clears the valid bits and loads the line length reset value;
//  the vertex store holds garbage until written. A stalled output freezes
//  every stage, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_face_normal_line_top #(
    parameter int VERTEX_SLOTS = 1024
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // slot[9:0] x[41:10] y[73:42] z[105:74] a[115:106] b[125:116] c[135:126]
    input  wire logic [135:0] s_tdata,
    // opcode[0]
    input  wire logic [0:0]   s_tuser,
    input  wire logic         s_tlast,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // mid_x[31:0] mid_y[63:32] mid_z[95:64] end_x[127:96] end_y[159:128]
    // end_z[191:160]
    output logic      [191:0] m_tdata,
    // degenerate[0]
    output logic      [0:0]   m_tuser,
    output logic              m_tlast,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [30:0]  cfg_data,
    input  wire logic         cfg_valid,
    output logic              cfg_ready
);

    localparam int AW = $clog2(VERTEX_SLOTS);
    localparam int SQ = tfnl_pkg::SQRT_STAGES;
    localparam int DQ = tfnl_pkg::DIV_STAGES;

    logic        adv;
    logic        in_acc;
    logic [30:0] line_length_reg;

    // Advance every stage unless the output holds an untaken beat
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign in_acc   = s_tvalid && s_tready;

    // Configuration register
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= tfnl_pkg::LINE_LENGTH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            line_length_reg <= cfg_data;
        end
    end

    // ---------------- vertex store ----------------
    logic [16:0]   wslot;
    logic [16:0]   cslot [3];
    logic [2:0]    cinr;
    logic          wr_en;
    logic [95:0]   rd_data [3];

    assign wslot    = 17'(s_tdata[9:0]);
    assign cslot[0] = 17'(s_tdata[115:106]);
    assign cslot[1] = 17'(s_tdata[125:116]);
    assign cslot[2] = 17'(s_tdata[135:126]);
    assign wr_en    = in_acc && (s_tuser[0] == tfnl_pkg::OP_VERTEX)
                      && (wslot < 17'(VERTEX_SLOTS));

    // One copy of the store per corner, all written together
    for (genvar k = 0; k < 3; k++)
    begin : g_store
        assign cinr[k] = cslot[k] < 17'(VERTEX_SLOTS);
        tfnl_ram #(
            .WIDTH (96),
            .DEPTH (VERTEX_SLOTS)
        ) u_ram (
            .clk     (clk),
            .wr_en   (wr_en),
            .wr_addr (wslot[AW-1:0]),
            .wr_data (s_tdata[105:10]),
            .rd_en   (adv),
            .rd_addr (cslot[k][AW-1:0]),
            .rd_data (rd_data[k])
        );
    end

    // ---------------- stage 1: store read ----------------
    logic       v1_reg, last1_reg;
    logic [2:0] inr1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg    <= in_acc && (s_tuser[0] == tfnl_pkg::OP_FACE);
            last1_reg <= s_tlast;
            inr1_reg  <= cinr;
        end
    end

    // ---------------- stage 2: edges and coordinate sums ----------------
    logic signed [31:0] va [3];
    logic signed [31:0] vb [3];
    logic signed [31:0] vc [3];
    logic               v2_reg, last2_reg;
    logic signed [32:0] e1_reg [3];
    logic signed [32:0] e2_reg [3];
    logic signed [33:0] sum_reg [3];

    // Zero corners that name a slot beyond the store
    for (genvar k = 0; k < 3; k++)
    begin : g_corner
        assign va[k] = inr1_reg[0] ? $signed(rd_data[0][32*k +: 32]) : 32'sd0;
        assign vb[k] = inr1_reg[1] ? $signed(rd_data[1][32*k +: 32]) : 32'sd0;
        assign vc[k] = inr1_reg[2] ? $signed(rd_data[2][32*k +: 32]) : 32'sd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg    <= v1_reg;
            last2_reg <= last1_reg;
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k]  <= 33'(vb[k]) - 33'(va[k]);
                e2_reg[k]  <= 33'(vc[k]) - 33'(va[k]);
                sum_reg[k] <= 34'(va[k]) + 34'(vb[k]) + 34'(vc[k]);
            end
        end
    end

    // ---------------- stage 3: products ----------------
    logic               v3_reg, last3_reg;
    logic signed [65:0] pa_reg [3];
    logic signed [65:0] pb_reg [3];
    logic        [66:0] cprod_reg [3];
    logic        [2:0]  cneg_reg;
    logic        [33:0] cmag [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_cmag
        assign cmag[k] = (sum_reg[k][33] ? 34'(-sum_reg[k]) : 34'(sum_reg[k])) + 34'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg    <= v2_reg;
            last3_reg <= last2_reg;
            pa_reg[0] <= e1_reg[1] * e2_reg[2];
            pb_reg[0] <= e1_reg[2] * e2_reg[1];
            pa_reg[1] <= e1_reg[2] * e2_reg[0];
            pb_reg[1] <= e1_reg[0] * e2_reg[2];
            pa_reg[2] <= e1_reg[0] * e2_reg[1];
            pb_reg[2] <= e1_reg[1] * e2_reg[0];
            for (int k = 0; k < 3; k++)
            begin
                cprod_reg[k] <= 67'(cmag[k]) * 67'(tfnl_pkg::RECIP3);
                cneg_reg[k]  <= sum_reg[k][33];
            end
        end
    end

    // ---------------- stage 4: cross product and centroid ----------------
    logic               v4_reg, last4_reg;
    logic signed [66:0] cross_reg [3];
    logic        [31:0] mid4_reg [3];
    logic        [31:0] cq [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_cq
        assign cq[k] = cprod_reg[k][tfnl_pkg::RECIP3_SHIFT +: 32];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg    <= v3_reg;
            last4_reg <= last3_reg;
            for (int k = 0; k < 3; k++)
            begin
                cross_reg[k] <= 67'(pa_reg[k]) - 67'(pb_reg[k]);
                mid4_reg[k]  <= cneg_reg[k] ? -cq[k] : cq[k];
            end
        end
    end

    // ---------------- stage 5: magnitudes and degenerate test ----------------
    tfnl_pkg::side_t side5_reg;
    logic [65:0]     mag5_reg [3];
    logic [65:0]     mag4 [3];

    for (genvar k = 0; k < 3; k++)
    begin : g_mag
        assign mag4[k] = cross_reg[k][66] ? 66'(-cross_reg[k]) : 66'(cross_reg[k]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side5_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            side5_reg.valid <= v4_reg;
            side5_reg.last  <= last4_reg;
            side5_reg.degen <= (cross_reg[0] == '0) && (cross_reg[1] == '0)
                               && (cross_reg[2] == '0);
            for (int k = 0; k < 3; k++)
            begin
                side5_reg.neg[k] <= cross_reg[k][66];
                side5_reg.mid[k] <= mid4_reg[k];
                mag5_reg[k]      <= mag4[k];
            end
        end
    end

    // ---------------- stage 6: block shift amount ----------------
    tfnl_pkg::side_t side6_reg;
    logic [65:0]     mag6_reg [3];
    logic [5:0]      sh6_reg;
    logic [65:0]     mag_or;
    logic [6:0]      bitlen;
    logic [5:0]      sh5;

    assign mag_or = mag5_reg[0] | mag5_reg[1] | mag5_reg[2];

    // Find the length of the widest magnitude
    always_comb
    begin
        bitlen = '0;
        for (int i = 0; i < 66; i++)
        begin
            if (mag_or[i])
            begin
                bitlen = 7'(i + 1);
            end
        end
        sh5 = (bitlen > 7'(tfnl_pkg::RC_BITS)) ? 6'(bitlen - 7'(tfnl_pkg::RC_BITS)) : 6'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side6_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            side6_reg <= side5_reg;
            mag6_reg  <= mag5_reg;
            sh6_reg   <= sh5;
        end
    end

    // ---------------- stage 7: shifted components ----------------
    tfnl_pkg::side_t side7_reg;
    logic [29:0]     rc7_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side7_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            side7_reg <= side6_reg;
            for (int k = 0; k < 3; k++)
            begin
                rc7_reg[k] <= 30'(mag6_reg[k] >> sh6_reg);
            end
        end
    end

    // ---------------- stage 8: squares and scaled numerators ----------------
    tfnl_pkg::side_t side8_reg;
    logic [59:0]     sq8_reg [3];
    logic [60:0]     num8_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side8_reg.valid <= 1'b0;
        end
        else if (adv)
        begin
            side8_reg <= side7_reg;
            for (int k = 0; k < 3; k++)
            begin
                sq8_reg[k]  <= 60'(rc7_reg[k]) * 60'(rc7_reg[k]);
                num8_reg[k] <= 61'(rc7_reg[k]) * 61'(line_length_reg);
            end
        end
    end

    // ---------------- square root pipeline ----------------
    tfnl_pkg::sqrt_t sqrt_reg  [SQ+1];
    tfnl_pkg::sqrt_t sqrt_next [SQ+1];

    // Load the sum of squares and the scaled numerators
    always_comb
    begin
        sqrt_next[0]      = sqrt_reg[0];
        sqrt_next[0].side = side8_reg;
        sqrt_next[0].rad  = 64'(sq8_reg[0]) + 64'(sq8_reg[1]) + 64'(sq8_reg[2]);
        sqrt_next[0].rem  = '0;
        sqrt_next[0].root = '0;
        for (int k = 0; k < 3; k++)
        begin
            sqrt_next[0].num[k] = num8_reg[k];
        end
    end

    // Two root bits per stage
    for (genvar i = 0; i < SQ; i++)
    begin : g_sqrt
        always_comb
        begin
            logic [35:0] t;
            logic [35:0] trial;
            sqrt_next[i+1] = sqrt_reg[i];
            for (int j = 0; j < 2; j++)
            begin
                t     = {sqrt_next[i+1].rem, sqrt_next[i+1].rad[63:62]};
                trial = {2'b00, sqrt_next[i+1].root, 2'b01};
                sqrt_next[i+1].rad = {sqrt_next[i+1].rad[61:0], 2'b00};
                if (t >= trial)
                begin
                    sqrt_next[i+1].rem  = 34'(t - trial);
                    sqrt_next[i+1].root = {sqrt_next[i+1].root[30:0], 1'b1};
                end
                else
                begin
                    sqrt_next[i+1].rem  = 34'(t);
                    sqrt_next[i+1].root = {sqrt_next[i+1].root[30:0], 1'b0};
                end
            end
        end
    end

    for (genvar i = 0; i <= SQ; i++)
    begin : g_sqrt_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sqrt_reg[i].side.valid <= 1'b0;
            end
            else if (adv)
            begin
                sqrt_reg[i] <= sqrt_next[i];
            end
        end
    end

    // ---------------- divider pipeline ----------------
    tfnl_pkg::qdiv_t div_reg  [DQ+1];
    tfnl_pkg::qdiv_t div_next [DQ+1];

    // Take a zero length as one, add half the length for rounding and split the dividend
    always_comb
    begin
        logic [31:0] len;
        logic [61:0] dvd;
        len = (sqrt_reg[SQ].root == '0) ? 32'd1 : sqrt_reg[SQ].root;
        div_next[0]      = div_reg[0];
        div_next[0].side = sqrt_reg[SQ].side;
        div_next[0].len  = len;
        for (int k = 0; k < 3; k++)
        begin
            dvd = 62'(sqrt_reg[SQ].num[k]) + 62'(len >> 1);
            div_next[0].rem[k] = 33'(dvd[61:32]);
            div_next[0].low[k] = dvd[31:0];
            div_next[0].quo[k] = '0;
        end
    end

    // Two quotient bits per stage in each lane
    for (genvar i = 0; i < DQ; i++)
    begin : g_div
        always_comb
        begin
            logic [33:0] t;
            div_next[i+1] = div_reg[i];
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 2; j++)
                begin
                    t = {div_next[i+1].rem[k], div_next[i+1].low[k][31]};
                    div_next[i+1].low[k] = {div_next[i+1].low[k][30:0], 1'b0};
                    if (t >= 34'(div_next[i+1].len))
                    begin
                        div_next[i+1].rem[k] = 33'(t - 34'(div_next[i+1].len));
                        div_next[i+1].quo[k] = {div_next[i+1].quo[k][30:0], 1'b1};
                    end
                    else
                    begin
                        div_next[i+1].rem[k] = 33'(t);
                        div_next[i+1].quo[k] = {div_next[i+1].quo[k][30:0], 1'b0};
                    end
                end
            end
        end
    end

    for (genvar i = 0; i <= DQ; i++)
    begin : g_div_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_reg[i].side.valid <= 1'b0;
            end
            else if (adv)
            begin
                div_reg[i] <= div_next[i];
            end
        end
    end

    // ---------------- output register ----------------
    logic [31:0] end_w [3];

    // Add the signed offset to the centroid and saturate; a degenerate face keeps the centroid
    always_comb
    begin
        logic signed [33:0] off;
        logic signed [33:0] tot;
        for (int k = 0; k < 3; k++)
        begin
            off = div_reg[DQ].side.neg[k] ? -$signed(34'(div_reg[DQ].quo[k]))
                                          : $signed(34'(div_reg[DQ].quo[k]));
            tot = $signed(34'($signed(div_reg[DQ].side.mid[k]))) + off;
            if (div_reg[DQ].side.degen)
            begin
                end_w[k] = div_reg[DQ].side.mid[k];
            end
            else if (tot > 34'sd2147483647)
            begin
                end_w[k] = 32'h7FFF_FFFF;
            end
            else if (tot < -34'sd2147483648)
            begin
                end_w[k] = 32'h8000_0000;
            end
            else
            begin
                end_w[k] = tot[31:0];
            end
        end
    end

    logic         m_tvalid_reg;
    logic [191:0] m_tdata_reg;
    logic         m_tuser_reg;
    logic         m_tlast_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m_tvalid_reg <= div_reg[DQ].side.valid;
            m_tdata_reg  <= {end_w[2], end_w[1], end_w[0],
                             div_reg[DQ].side.mid[2], div_reg[DQ].side.mid[1],
                             div_reg[DQ].side.mid[0]};
            m_tuser_reg  <= div_reg[DQ].side.degen;
            m_tlast_reg  <= div_reg[DQ].side.last;
        end
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;
    assign m_tlast    = m_tlast_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tfnl_checker.sv =====
// ----------------------------------------------------------------------------
// tfnl_checker
// Port-level checks on the face normal line block, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tfnl_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_tready,
    input wire logic [191:0] m_tdata,
    input wire logic [0:0]   m_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready
);

    // A stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output beat changed under stall");

    // With the output empty the block takes input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input not ready with output empty");

    // A stall at the output backs up to the input
    a_back: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input ready while output stalled");

    // A degenerate face ends its line at the centroid
    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[191:96] == m_tdata[95:0])
        else $error("degenerate face with line end off centroid");

endmodule

bind triangle_face_normal_line_top tfnl_checker u_tfnl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

`default_nettype wire
